[design/longest_bitonic_subsequence_macros.svh]
// ============================================================================
// Longest bitonic subsequence assertion macros
// Shared concurrent assertion forms used by the design files.
// ============================================================================
`ifndef LONGEST_BITONIC_SUBSEQUENCE_MACROS_SVH
`define LONGEST_BITONIC_SUBSEQUENCE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define LBS_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define LBS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define LBS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lbs_pkg.sv]
// ============================================================================
// Longest bitonic subsequence package
// Shared constants, controller states and controller/datapath interface types.
// ============================================================================
package lbs_pkg;

    localparam int DEF_MAX_ITEMS    = 8192;
    localparam int DEF_VALUE_WIDTH  = 32;
    localparam int LEN_WIDTH        = 14;
    localparam int LEN_MAX          = 16383;
    localparam int OUT_TDATA_WIDTH  = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_PLACE,
        ST_REV_INIT,
        ST_FETCH,
        ST_LOAD,
        ST_EMIT
    } lbs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_input;
        logic search_step;
        logic place;
        logic rev;
        logic rev_init;
        logic load_rev;
        logic emit;
    } lbs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_done;
        logic full;
        logic last_item;
        logic pos_last;
        logic out_busy;
    } lbs_status_t;

endpackage

[design/lbs_ctrl.sv]
// ============================================================================
// Longest bitonic subsequence controller
// Sequences the forward pass, the reverse pass and the result hand-off.
// ============================================================================
module lbs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tlast,
    output logic                 s_axis_tready,
    input  lbs_pkg::lbs_status_t status,
    output lbs_pkg::lbs_cmd_t    cmd
);

    lbs_pkg::lbs_state_t state_reg, state_next;
    logic                rev_reg, rev_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lbs_pkg::ST_IDLE;
            rev_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            rev_reg   <= rev_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        rev_next   = rev_reg;
        unique case (state_reg)
            lbs_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (!status.full) begin
                        state_next = lbs_pkg::ST_SEARCH_RD;
                    end else if (s_axis_tlast) begin
                        state_next = lbs_pkg::ST_REV_INIT;
                    end
                end
            end
            lbs_pkg::ST_SEARCH_RD: begin
                state_next = status.search_done ? lbs_pkg::ST_PLACE : lbs_pkg::ST_SEARCH_CMP;
            end
            lbs_pkg::ST_SEARCH_CMP: begin
                state_next = lbs_pkg::ST_SEARCH_RD;
            end
            lbs_pkg::ST_PLACE: begin
                if (rev_reg) begin
                    state_next = status.pos_last ? lbs_pkg::ST_EMIT : lbs_pkg::ST_FETCH;
                end else begin
                    state_next = status.last_item ? lbs_pkg::ST_REV_INIT : lbs_pkg::ST_IDLE;
                end
            end
            lbs_pkg::ST_REV_INIT: begin
                state_next = lbs_pkg::ST_FETCH;
                rev_next   = 1'b1;
            end
            lbs_pkg::ST_FETCH: begin
                state_next = lbs_pkg::ST_LOAD;
            end
            lbs_pkg::ST_LOAD: begin
                state_next = lbs_pkg::ST_SEARCH_RD;
            end
            lbs_pkg::ST_EMIT: begin
                if (!status.out_busy) begin
                    state_next = lbs_pkg::ST_IDLE;
                    rev_next   = 1'b0;
                end
            end
            default: begin
                state_next = lbs_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        cmd           = '0;
        cmd.rev       = rev_reg;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            lbs_pkg::ST_IDLE: begin
                s_axis_tready  = 1'b1;
                cmd.take_input = s_axis_tvalid;
            end
            lbs_pkg::ST_SEARCH_CMP: begin
                cmd.search_step = 1'b1;
            end
            lbs_pkg::ST_PLACE: begin
                cmd.place = 1'b1;
            end
            lbs_pkg::ST_REV_INIT: begin
                cmd.rev_init = 1'b1;
            end
            lbs_pkg::ST_LOAD: begin
                cmd.load_rev = 1'b1;
            end
            lbs_pkg::ST_EMIT: begin
                cmd.emit = !status.out_busy;
            end
            lbs_pkg::ST_SEARCH_RD,
            lbs_pkg::ST_FETCH: begin
            end
            default: begin
            end
        endcase
    end

endmodule

[design/lbs_dp.sv]
// ============================================================================
// Longest bitonic subsequence datapath
// Sample, tail and rise memories, binary search registers and result register.
// ============================================================================
`include "longest_bitonic_subsequence_macros.svh"

module lbs_dp #(
    parameter int MAX_ITEMS   = lbs_pkg::DEF_MAX_ITEMS,
    parameter int VALUE_WIDTH = lbs_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lbs_pkg::lbs_cmd_t                   cmd,
    output lbs_pkg::lbs_status_t                status,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    in_data,
    input  logic                                in_last,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lbs_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
    output logic [0:0]                          m_axis_tuser
);

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int LW = (CW + 1 > lbs_pkg::LEN_WIDTH) ? CW + 1 : lbs_pkg::LEN_WIDTH;
    localparam int PADW = lbs_pkg::OUT_TDATA_WIDTH - lbs_pkg::LEN_WIDTH;

    logic [VALUE_WIDTH-1:0] stored_mem [MAX_ITEMS];
    logic [VALUE_WIDTH-1:0] tail_mem   [MAX_ITEMS];
    logic [CW-1:0]          rise_mem   [MAX_ITEMS];

    logic [VALUE_WIDTH-1:0] stored_rdata_reg, tail_rdata_reg;
    logic [CW-1:0]          rise_rdata_reg;

    logic [CW-1:0] item_count_reg, item_count_next;
    logic [CW-1:0] tail_count_reg, tail_count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] rise_reg, rise_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic last_reg, last_next;
    logic drop_reg, drop_next;
    logic [lbs_pkg::LEN_WIDTH-1:0] best_reg, best_next;
    logic out_valid_reg, out_valid_next;
    logic [lbs_pkg::LEN_WIDTH-1:0] out_len_reg;
    logic out_drop_reg;

    logic [VALUE_WIDTH-1:0] in_value;
    logic [CW-1:0]          mid;
    logic [CW-1:0]          place_len;
    logic [CW-1:0]          min_len;
    logic [CW-1:0]          rd_pos;
    logic [LW-1:0]          len_full;
    logic [lbs_pkg::LEN_WIDTH-1:0] len_sat;
    logic                   tail_less;
    logic                   full;

    // Biased form: flipping the sign bit makes unsigned order match signed order.
    assign in_value  = in_data[VALUE_WIDTH-1:0] ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign tail_less = tail_rdata_reg < value_reg;
    assign place_len = lo_reg + CW'(1);
    assign min_len   = (rise_reg < place_len) ? rise_reg : place_len;
    assign len_full  = (LW'(min_len) << 1) - LW'(1);
    assign len_sat   = (len_full > LW'(lbs_pkg::LEN_MAX)) ?
                       lbs_pkg::LEN_WIDTH'(lbs_pkg::LEN_MAX) : len_full[lbs_pkg::LEN_WIDTH-1:0];
    assign rd_pos    = pos_reg - CW'(1);
    assign full      = (item_count_reg == CW'(MAX_ITEMS));

    assign status.search_done = (lo_reg >= hi_reg);
    assign status.full        = full;
    assign status.last_item   = last_reg;
    assign status.pos_last    = (pos_reg == CW'(1));
    assign status.out_busy    = out_valid_reg && !m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PADW{1'b0}}, out_len_reg};
    assign m_axis_tuser  = out_drop_reg;

    // Memories.
    always_ff @(posedge aclk) begin
        if (cmd.take_input && !full) begin
            stored_mem[item_count_reg[IW-1:0]] <= in_value;
        end
        stored_rdata_reg <= stored_mem[rd_pos[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.place) begin
            tail_mem[lo_reg[IW-1:0]] <= value_reg;
        end
        tail_rdata_reg <= tail_mem[mid[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.place && !cmd.rev) begin
            rise_mem[item_count_reg[IW-1:0]] <= place_len;
        end
        rise_rdata_reg <= rise_mem[rd_pos[IW-1:0]];
    end

    always_comb begin
        item_count_next = item_count_reg;
        tail_count_next = tail_count_reg;
        pos_next        = pos_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        rise_next       = rise_reg;
        value_next      = value_reg;
        last_next       = last_reg;
        drop_next       = drop_reg;
        best_next       = best_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;

        if (cmd.take_input) begin
            value_next = in_value;
            last_next  = in_last;
            lo_next    = '0;
            hi_next    = tail_count_reg;
            if (full) begin
                drop_next = 1'b1;
            end
        end

        if (cmd.search_step) begin
            if (tail_less) begin
                lo_next = mid + CW'(1);
            end else begin
                hi_next = mid;
            end
        end

        if (cmd.place) begin
            if (lo_reg == tail_count_reg) begin
                tail_count_next = tail_count_reg + CW'(1);
            end
            if (cmd.rev) begin
                if (len_sat > best_reg) begin
                    best_next = len_sat;
                end
                pos_next = rd_pos;
            end else begin
                item_count_next = item_count_reg + CW'(1);
            end
        end

        if (cmd.rev_init) begin
            tail_count_next = '0;
            best_next       = '0;
            pos_next        = item_count_reg;
        end

        if (cmd.load_rev) begin
            value_next = stored_rdata_reg;
            rise_next  = rise_rdata_reg;
            lo_next    = '0;
            hi_next    = tail_count_reg;
        end

        if (cmd.emit) begin
            out_valid_next  = 1'b1;
            item_count_next = '0;
            tail_count_next = '0;
            best_next       = '0;
            drop_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg <= '0;
            tail_count_reg <= '0;
            pos_reg        <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            last_reg       <= 1'b0;
            drop_reg       <= 1'b0;
            best_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            item_count_reg <= item_count_next;
            tail_count_reg <= tail_count_next;
            pos_reg        <= pos_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            last_reg       <= last_next;
            drop_reg       <= drop_next;
            best_reg       <= best_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rise_reg  <= rise_next;
        value_reg <= value_next;
        if (cmd.emit) begin
            out_len_reg  <= best_reg;
            out_drop_reg <= drop_reg;
        end
    end

    `LBS_ASSERT_ALWAYS(a_tails_within_items, aclk, aresetn, tail_count_reg <= item_count_reg, "tail count exceeds item count")
    `LBS_ASSERT_ALWAYS(a_search_bounds, aclk, aresetn, lo_reg <= hi_reg, "search low bound passed high bound")
    `LBS_ASSERT_NEXT(a_drop_marked, aclk, aresetn, cmd.take_input && full, drop_reg, "dropped beat not flagged")
    `LBS_ASSERT_IMPL(a_length_odd, aclk, aresetn, out_valid_reg, out_len_reg[0], "emitted length is even")

endmodule

[design/longest_bitonic_subsequence.sv]
// Each sample is binary searched over the T tails held so far, then placed;
// the marked beat then runs a reverse pass over the N kept samples before the
// result register loads. Throughput is set by the single registered read port
// of the tail memory, read before each search compare; a new sample is taken
// only once the last is placed. Reset (aresetn, synchronous, active low) clears
// counters, flags and result valid; memories are not cleared, need no clearing pass.
// ============================================================================
// Longest bitonic subsequence
// Streams signed samples, finds rise lengths by patience sorting, then fall
// lengths in reverse, and reports the longest symmetric bitonic length.
// ============================================================================
module longest_bitonic_subsequence #(
    parameter int MAX_ITEMS   = lbs_pkg::DEF_MAX_ITEMS,
    parameter int VALUE_WIDTH = lbs_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input beats: one sequence sample each, tlast marks the final sample.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // sample_value
    input  logic                                s_axis_tlast,  // is_last
    // Result beats: one per sequence.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lbs_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,  // wave_length
    output logic [0:0]                          m_axis_tuser   // overflowed
);

    // The controller only issues commands; all storage and arithmetic lives in
    // the datapath. They talk through one command and one status bundle.
    lbs_pkg::lbs_cmd_t    cmd;
    lbs_pkg::lbs_status_t status;

    // The controller walks each sample through a binary search over the tail
    // table, then, after the marked beat, replays the stored samples from last
    // to first to build fall lengths and track the best symmetric length.
    lbs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // The datapath owns the three memories and an output register, so a new
    // sequence can start while the previous result still waits to be taken.
    lbs_dp #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .in_data       (s_axis_tdata),
        .in_last       (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[bench/longest_bitonic_subsequence_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// Longest bitonic subsequence testbench
// Streams signed sample sequences into the block and checks every result beat
// against a patience-sorting predictor kept inside the bench. It covers
// directed corner sequences, a sequence that overruns the sample store,
// back-pressure that stalls the input, and randomly shaped sequences, with
// and without random idling on both sides.
// ============================================================================
module longest_bitonic_subsequence_tb;

    localparam int          CAPACITY       = lbs_pkg::DEF_MAX_ITEMS;
    localparam int          SAMPLE_WIDTH   = lbs_pkg::DEF_VALUE_WIDTH;
    localparam logic [31:0] SIGN_FLIP      = 32'h8000_0000;
    localparam logic [31:0] MOST_NEGATIVE  = 32'h8000_0000;
    localparam logic [31:0] MOST_POSITIVE  = 32'h7FFF_FFFF;
    // A full store runs its whole reverse pass without a single beat moving, so
    // the quiet limit sits well above that pass.
    localparam int          QUIET_LIMIT    = 1_000_000;
    localparam int          SETTLE_CYCLES  = 256;
    localparam int          LONG_STALL     = 500;

    typedef struct packed {
        logic [lbs_pkg::LEN_WIDTH-1:0] wave;
        logic                          ovf;
    } wave_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // sample_value
    logic        s_axis_tlast;   // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // wave_length, zero padded
    logic [0:0]  m_axis_tuser;   // overflowed

    longest_bitonic_subsequence #(
        .MAX_ITEMS   (CAPACITY),
        .VALUE_WIDTH (SAMPLE_WIDTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Predictor state: samples are held with the sign bit flipped so that an
    // unsigned compare orders them as signed values.
    logic [31:0]          kept_keys  [CAPACITY];
    logic [31:0]          tail_keys  [CAPACITY];
    int                   rise_len   [CAPACITY];
    int                   kept_count;
    int                   tail_count;
    bit                   dropped;
    wave_result_t         expected_waves[$];

    int                   mismatches;
    int                   samples_sent;
    int                   sequences_sent;
    int                   results_seen;
    int                   quiet_cycles;
    int                   rx_stall_left;
    int                   rx_gap_left;
    bit                   idle_on;

    // Binary search for the first tail not below the key; returns run length.
    function automatic int place_tail(input logic [31:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = tail_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (tail_keys[mid] < key) lo = mid + 1;
            else                      hi = mid;
        end
        if (lo >= CAPACITY) lo = CAPACITY - 1;
        tail_keys[lo] = key;
        if (lo == tail_count) tail_count++;
        return lo + 1;
    endfunction

    function automatic void absorb_sample(input logic [31:0] value, input logic last);
        logic [31:0] key;
        int          fall;
        int          peak;
        int          len;
        int          best;
        key = value ^ SIGN_FLIP;
        if (kept_count < CAPACITY) begin
            kept_keys[kept_count] = key;
            rise_len[kept_count]  = place_tail(key);
            kept_count++;
        end else begin
            dropped = 1'b1;
        end
        if (last) begin
            // Reverse pass: the same search over the samples last to first
            // gives the falling run that starts at each position.
            tail_count = 0;
            best       = 0;
            for (int i = kept_count; i > 0; i--) begin
                fall = place_tail(kept_keys[i-1]);
                peak = (rise_len[i-1] < fall) ? rise_len[i-1] : fall;
                len  = 2 * peak - 1;
                if (len > lbs_pkg::LEN_MAX) len = lbs_pkg::LEN_MAX;
                if (len > best) best = len;
            end
            expected_waves.push_back('{wave: best[lbs_pkg::LEN_WIDTH-1:0], ovf: dropped});
            kept_count = 0;
            tail_count = 0;
            dropped    = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatches++;
    endtask

    // Input side monitor feeds the predictor.
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            absorb_sample(s_axis_tdata, s_axis_tlast);
        end
    end

    // Result side monitor compares each beat with the oldest expectation.
    always @(posedge aclk) begin
        wave_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_waves.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected, tdata=%0d",
                                          m_axis_tdata));
            end else begin
                want = expected_waves.pop_front();
                if (m_axis_tdata !== {{(16-lbs_pkg::LEN_WIDTH){1'b0}}, want.wave}) begin
                    report_mismatch($sformatf("wave_length got %0d want %0d",
                                              m_axis_tdata, want.wave));
                end
                if (m_axis_tuser !== want.ovf) begin
                    report_mismatch($sformatf("overflowed got %0b want %0b",
                                              m_axis_tuser, want.ovf));
                end
            end
        end
    end

    // Receiver: a requested long stall first, then random short gaps while idling is on.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left--;
        end else if (rx_gap_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap_left--;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            rx_gap_left = $urandom_range(1, 6) - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] Watchdog: no beat moved for %0d cycles", $realtime,
                         QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic sender_pause(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Offers one sample and returns in the step of its accepting edge, or after a
    // random idle pause; without that pause a following call keeps tvalid high without a gap.
    task automatic send_sample(input logic [31:0] value, input bit last);
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        samples_sent++;
        if (last) sequences_sent++;
        if (idle_on && $urandom_range(0, 3) == 0) sender_pause($urandom_range(1, 6));
    endtask

    task automatic send_sequence(input logic [31:0] vals[$]);
        foreach (vals[i]) send_sample(vals[i], i == vals.size() - 1);
    endtask

    // Holds the input side quiet until every expected result has arrived.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_waves.size() != 0);
    endtask

    task automatic test_directed_corners();
        idle_on = 1'b1;
        send_sequence('{MOST_NEGATIVE});
        send_sequence('{MOST_POSITIVE});
        send_sequence('{MOST_NEGATIVE, MOST_POSITIVE});
        // Peak at the top of the range with both extremes on the slopes.
        send_sequence('{MOST_NEGATIVE, 32'd0, MOST_POSITIVE, 32'hFFFF_FFFF, MOST_NEGATIVE});
        // Equal samples do not extend a strict run.
        send_sequence('{32'd7, 32'd7, 32'd7});
        send_sequence('{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF});
        send_sequence('{32'd5, 32'd4, 32'd3, 32'd2});
        wait_for_results();
    endtask

    // Fills the store with one long rise-then-fall, then overruns it so that
    // the marked sample itself is dropped; a short sequence follows to see
    // that the drop flag was cleared.
    task automatic test_capacity_overflow();
        logic [31:0] vals[$];
        int          half;
        idle_on = 1'b0;
        half    = CAPACITY / 2;
        for (int i = 0; i < half; i++) vals.push_back(32'(i * 3 - 6000));
        for (int i = half; i < CAPACITY - 1; i++)
            vals.push_back(32'((CAPACITY - 2 - i) * 3 - 6000));
        vals.push_back(MOST_NEGATIVE);
        vals.push_back(MOST_POSITIVE);
        vals.push_back(32'd0);
        send_sequence(vals);
        wait_for_results();
        send_sequence('{32'd1, 32'd3, 32'd2});
        wait_for_results();
    endtask

    // The receiver stalls for a long stretch while short sequences keep
    // coming, so results back up and the input side stalls.
    task automatic test_result_backpressure();
        idle_on       = 1'b0;
        rx_stall_left = LONG_STALL;
        for (int s = 0; s < 8; s++) begin
            send_sequence('{32'($urandom_range(0, 9)), 32'($urandom_range(0, 9)),
                            32'($urandom_range(0, 9))});
        end
        wait_for_results();
    endtask

    task automatic build_random_sequence(output logic [31:0] vals[$]);
        int len;
        int shape;
        int v;
        int turn;
        vals.delete();
        case ($urandom_range(0, 19))
            0:               len = $urandom_range(61, 300);
            1, 2, 3:         len = $urandom_range(21, 60);
            default:         len = $urandom_range(1, 20);
        endcase
        shape = $urandom_range(0, 4);
        v     = $urandom_range(0, 2000) - 1000;
        turn  = $urandom_range(0, len - 1);
        for (int k = 0; k < len; k++) begin
            case (shape)
                0: begin
                    // Rise then fall, with flat steps to probe strictness.
                    v = (k <= turn) ? v + $urandom_range(0, 3) : v - $urandom_range(0, 3);
                    vals.push_back(32'(v));
                end
                1:       vals.push_back(32'($urandom_range(0, 8) - 4));
                2:       vals.push_back($urandom);
                3: begin
                    v = v + $urandom_range(0, 40) - 20;
                    vals.push_back(32'(v));
                end
                default: vals.push_back(($urandom_range(0, 1) != 0) ? ~32'(k) : 32'(k));
            endcase
        end
    endtask

    task automatic test_random_sequences(input int item_target, input bit with_idle);
        logic [31:0] vals[$];
        int          start;
        idle_on = with_idle;
        start   = samples_sent;
        while (samples_sent - start < item_target) begin
            build_random_sequence(vals);
            send_sequence(vals);
            if (with_idle && $urandom_range(0, 9) == 0) wait_for_results();
        end
        wait_for_results();
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tlast   <= 1'b0;
        kept_count     = 0;
        tail_count     = 0;
        dropped        = 1'b0;
        mismatches     = 0;
        samples_sent   = 0;
        sequences_sent = 0;
        results_seen   = 0;
        quiet_cycles   = 0;
        rx_stall_left  = 0;
        rx_gap_left    = 0;
        idle_on        = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_corners();
        test_capacity_overflow();
        test_result_backpressure();
        test_random_sequences(600, 1'b1);
        test_random_sequences(150, 1'b0);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_waves.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_waves.size()));
        end
        $display("Run covered %0d sequences and %0d samples, including a store overrun,",
                 sequences_sent, samples_sent);
        $display("a long result stall and random idling; %0d results checked, %0d mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
